>>> hw/rtl/assert_macros.svh
// assertion helpers, clocked on clock and quiet during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHECK_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/cct_pkg.sv
package cct_pkg;

   // request commands
   localparam logic [1:0] CMD_UPDATE   = 2'd0;
   localparam logic [1:0] CMD_TIMELINE = 2'd1;
   localparam logic [1:0] CMD_DELTA    = 2'd2;

   localparam logic [9:0]  FREQ_RESET  = 10'd168;
   localparam logic [19:0] HZ_PER_MHZ  = 20'd1000000;
   localparam logic [19:0] KHZ_PER_MHZ = 20'd1000;

   localparam int PC_W = 3;

   // datapath actions
   typedef enum logic [2:0] {
      OP_NOP,
      OP_LOAD,
      OP_DIV,
      OP_SPLIT_SEC,
      OP_SPLIT_MS,
      OP_EMIT
   } op_type;

   // jump conditions
   typedef enum logic [2:0] {
      JC_NEXT,
      JC_NO_REQ,
      JC_NOT_QUERY,
      JC_CNT,
      JC_DELTA,
      JC_OUT_BUSY
   } cond_type;

   typedef struct packed {
      op_type           op;
      cond_type         cond;
      logic [PC_W-1:0]  target;
   } ctrl_type;

   localparam logic [PC_W-1:0] PC_IDLE   = 3'd0;
   localparam logic [PC_W-1:0] PC_CHECK  = 3'd1;
   localparam logic [PC_W-1:0] PC_DIV_F  = 3'd2;
   localparam logic [PC_W-1:0] PC_SEC    = 3'd3;
   localparam logic [PC_W-1:0] PC_DIV_S  = 3'd4;
   localparam logic [PC_W-1:0] PC_MS     = 3'd5;
   localparam logic [PC_W-1:0] PC_DIV_MS = 3'd6;
   localparam logic [PC_W-1:0] PC_EMIT   = 3'd7;

   // microcode rom
   function automatic ctrl_type ucode(input logic [PC_W-1:0] pc);
      ctrl_type w;
      w = '{op: OP_NOP, cond: JC_NEXT, target: PC_IDLE};
      unique case (pc)
         PC_IDLE:   w = '{op: OP_LOAD,      cond: JC_NO_REQ,    target: PC_IDLE};
         PC_CHECK:  w = '{op: OP_NOP,       cond: JC_NOT_QUERY, target: PC_EMIT};
         PC_DIV_F:  w = '{op: OP_DIV,       cond: JC_CNT,       target: PC_DIV_F};
         PC_SEC:    w = '{op: OP_SPLIT_SEC, cond: JC_DELTA,     target: PC_EMIT};
         PC_DIV_S:  w = '{op: OP_DIV,       cond: JC_CNT,       target: PC_DIV_S};
         PC_MS:     w = '{op: OP_SPLIT_MS,  cond: JC_NEXT,      target: PC_IDLE};
         PC_DIV_MS: w = '{op: OP_DIV,       cond: JC_CNT,       target: PC_DIV_MS};
         PC_EMIT:   w = '{op: OP_EMIT,      cond: JC_OUT_BUSY,  target: PC_EMIT};
         default:   w = '{op: OP_NOP,       cond: JC_NEXT,      target: PC_IDLE};
      endcase
      return w;
   endfunction

endpackage

>>> hw/rtl/cycle_counter_timebase_top.sv
// channel | direction | handshake           | payload
// req     | in        | req_valid/req_stall | req_cmd, req_counter_now, req_prev_stamp
// rsp     | out       | rsp_valid/rsp_stall | seconds, millis/micros parts, totals, deltas
// csr     | in        | csr_valid/csr_ready | csr_cpu_freq_mhz
//
// one request at a time; a timeline request runs the divider three times before the result load,
// a delta request once and an update not at all (a two-bit-per-cycle restoring divider)
// total micros = total cycles / mhz, then split by 1e6 and by 1000 on the same divider
// synchronous active-high reset clears wrap count, last sample and sequencer and sets the frequency to 168
// a result waits in the output register; the next request is taken meanwhile, and only
// the emit step waits if the previous result is still stalled
`include "assert_macros.svh"

module cycle_counter_timebase_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_counter_now,
   input  logic [31:0] req_prev_stamp,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [44:0] rsp_seconds,
   output logic [9:0]  rsp_millis_part,
   output logic [9:0]  rsp_micros_part,
   output logic [63:0] rsp_total_micros,
   output logic [31:0] rsp_delta_cycles,
   output logic [31:0] rsp_delta_micros,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [9:0]  csr_cpu_freq_mhz
);

   // sequencer and tracking state
   logic [cct_pkg::PC_W-1:0] pc_ff, pc_in;
   logic [31:0] wrap_ff, wrap_in;
   logic [31:0] last_ff, last_in;
   logic [9:0]  freq_ff, freq_in;
   logic [1:0]  cmd_ff, cmd_in;

   // divider datapath
   logic [63:0] dvd_ff, dvd_in;
   logic [19:0] rem_ff, rem_in;
   logic [19:0] dvs_ff, dvs_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [63:0] tm_ff, tm_in;
   logic [44:0] sec_ff, sec_in;
   logic [31:0] delta_ff, delta_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [44:0] seconds_ff, seconds_in;
   logic [9:0]  millis_ff, millis_in;
   logic [9:0]  micros_ff, micros_in;
   logic [63:0] total_ff, total_in;
   logic [31:0] dcyc_ff, dcyc_in;
   logic [31:0] dus_ff, dus_in;

   cct_pkg::ctrl_type ctrl;
   logic        req_fire;
   logic        out_busy;
   logic        jump;
   logic [20:0] trial1, trial2;
   logic        ge1, ge2;
   logic [19:0] rem1, rem2;
   logic [63:0] dvd1, dvd2;
   logic [9:0]  mhz_eff;

   assign ctrl      = cct_pkg::ucode(pc_ff);
   assign req_stall = (pc_ff != cct_pkg::PC_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign out_busy  = rsp_valid_ff && rsp_stall;
   assign csr_ready = (pc_ff == cct_pkg::PC_IDLE);
   assign mhz_eff   = (freq_ff == 10'd0) ? 10'd1 : freq_ff;

   // two restoring divide steps per cycle
   assign trial1 = {rem_ff, dvd_ff[63]};
   assign ge1    = trial1 >= {1'b0, dvs_ff};
   assign rem1   = ge1 ? 20'(trial1 - {1'b0, dvs_ff}) : trial1[19:0];
   assign dvd1   = {dvd_ff[62:0], ge1};
   assign trial2 = {rem1, dvd1[63]};
   assign ge2    = trial2 >= {1'b0, dvs_ff};
   assign rem2   = ge2 ? 20'(trial2 - {1'b0, dvs_ff}) : trial2[19:0];
   assign dvd2   = {dvd1[62:0], ge2};

   always_comb begin
      jump = 1'b0;
      case (ctrl.cond)
         cct_pkg::JC_NO_REQ:    jump = !req_fire;
         cct_pkg::JC_NOT_QUERY: jump = (cmd_ff != cct_pkg::CMD_TIMELINE) &&
                                       (cmd_ff != cct_pkg::CMD_DELTA);
         cct_pkg::JC_CNT:       jump = (cnt_ff != 5'd0);
         cct_pkg::JC_DELTA:     jump = (cmd_ff == cct_pkg::CMD_DELTA);
         cct_pkg::JC_OUT_BUSY:  jump = out_busy;
         default:               jump = 1'b0;
      endcase
      pc_in = jump ? ctrl.target : pc_ff + 3'd1;
   end

   always_comb begin
      wrap_in    = wrap_ff;
      last_in    = last_ff;
      freq_in    = freq_ff;
      cmd_in     = cmd_ff;
      dvd_in     = dvd_ff;
      rem_in     = rem_ff;
      dvs_in     = dvs_ff;
      cnt_in     = cnt_ff;
      tm_in      = tm_ff;
      sec_in     = sec_ff;
      delta_in   = delta_ff;
      seconds_in = seconds_ff;
      millis_in  = millis_ff;
      micros_in  = micros_ff;
      total_in   = total_ff;
      dcyc_in    = dcyc_ff;
      dus_in     = dus_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (csr_valid && csr_ready) begin
         freq_in = csr_cpu_freq_mhz;
      end

      case (ctrl.op)
         cct_pkg::OP_LOAD: begin
            if (req_fire) begin
               // wrap tracking on every request
               if (req_counter_now < last_ff) begin
                  wrap_in = wrap_ff + 32'd1;
               end
               last_in  = req_counter_now;
               cmd_in   = req_cmd;
               delta_in = req_counter_now - req_prev_stamp;
               rem_in   = 20'd0;
               dvs_in   = {10'd0, mhz_eff};
               if (req_cmd == cct_pkg::CMD_TIMELINE) begin
                  dvd_in = {wrap_in, req_counter_now};
                  cnt_in = 5'd31;
               end else begin
                  dvd_in = {req_counter_now - req_prev_stamp, 32'd0};
                  cnt_in = 5'd15;
               end
            end
         end
         cct_pkg::OP_DIV: begin
            dvd_in = dvd2;
            rem_in = rem2;
            cnt_in = cnt_ff - 5'd1;
         end
         cct_pkg::OP_SPLIT_SEC: begin
            // quotient is total or delta micros, now split off whole seconds
            tm_in  = dvd_ff;
            rem_in = 20'd0;
            dvs_in = cct_pkg::HZ_PER_MHZ;
            cnt_in = 5'd31;
         end
         cct_pkg::OP_SPLIT_MS: begin
            // micros within the second, twenty bits, divided by 1000
            sec_in = dvd_ff[44:0];
            dvd_in = {rem_ff, 44'd0};
            rem_in = 20'd0;
            dvs_in = cct_pkg::KHZ_PER_MHZ;
            cnt_in = 5'd9;
         end
         cct_pkg::OP_EMIT: begin
            if (!out_busy) begin
               rsp_valid_in = 1'b1;
               seconds_in   = 45'd0;
               millis_in    = 10'd0;
               micros_in    = 10'd0;
               total_in     = 64'd0;
               dcyc_in      = 32'd0;
               dus_in       = 32'd0;
               if (cmd_ff == cct_pkg::CMD_TIMELINE) begin
                  seconds_in = sec_ff;
                  millis_in  = dvd_ff[9:0];
                  micros_in  = rem_ff[9:0];
                  total_in   = tm_ff;
               end else if (cmd_ff == cct_pkg::CMD_DELTA) begin
                  dcyc_in = delta_ff;
                  dus_in  = tm_ff[31:0];
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= cct_pkg::PC_IDLE;
         wrap_ff      <= 32'd0;
         last_ff      <= 32'd0;
         freq_ff      <= cct_pkg::FREQ_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         wrap_ff      <= wrap_in;
         last_ff      <= last_in;
         freq_ff      <= freq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff     <= cmd_in;
      dvd_ff     <= dvd_in;
      rem_ff     <= rem_in;
      dvs_ff     <= dvs_in;
      cnt_ff     <= cnt_in;
      tm_ff      <= tm_in;
      sec_ff     <= sec_in;
      delta_ff   <= delta_in;
      seconds_ff <= seconds_in;
      millis_ff  <= millis_in;
      micros_ff  <= micros_in;
      total_ff   <= total_in;
      dcyc_ff    <= dcyc_in;
      dus_ff     <= dus_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_seconds      = seconds_ff;
   assign rsp_millis_part  = millis_ff;
   assign rsp_micros_part  = micros_ff;
   assign rsp_total_micros = total_ff;
   assign rsp_delta_cycles = dcyc_ff;
   assign rsp_delta_micros = dus_ff;

   // an emit step that is not held back loads the output register
   `CHECK_NEXT(a_emit_loads, (pc_ff == cct_pkg::PC_EMIT) && !out_busy, rsp_valid_ff,
               "emit lost")
   // wrap count moves only when a request is taken
   `CHECK_NEXT(a_wrap_hold, !req_fire, $stable(wrap_ff), "wrap count moved without request")
   // split parts stay below one thousand
   `CHECK_NOW(a_parts_range, rsp_valid_ff,
              (millis_ff < 10'd1000) && (micros_ff < 10'd1000), "part out of range")
   // delta and timeline fields never both carry data
   `CHECK_NOW(a_field_excl, rsp_valid_ff && (dcyc_ff != 32'd0),
              (total_ff == 64'd0) && (seconds_ff == 45'd0), "mixed result fields")

endmodule
